// File: sv/bat_pkg.sv
// Package for the bus address tokenizer: token and part codes, character
// constants and the record passed from the front end to the back end.
// No dependencies.
package bat_pkg;

  // Token codes seen on token_kind_o.
  typedef enum logic [3:0] {
    TK_TRANSPORT_CHAR = 4'd0,
    TK_KEY_CHAR       = 4'd1,
    TK_VALUE_BYTE     = 4'd2,
    TK_END_TRANSPORT  = 4'd3,
    TK_END_KEY        = 4'd4,
    TK_END_VALUE      = 4'd5,
    TK_END_ADDRESS    = 4'd6,
    TK_DONE           = 4'd7,
    TK_ERROR          = 4'd8
  } tok_kind_e;

  // Part of the address that is currently open.
  typedef enum logic [1:0] {
    PART_TRANSPORT = 2'd0,
    PART_KEY       = 2'd1,
    PART_VALUE     = 2'd2
  } part_e;

  // Most tokens that one character can produce.
  localparam int unsigned MaxTokens = 4;

  // Characters with a meaning to the parser.
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_DIG_0   = 8'h30;
  localparam logic [7:0] CH_DIG_9   = 8'h39;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_F    = 8'h46;
  localparam logic [7:0] CH_LO_A    = 8'h61;
  localparam logic [7:0] CH_LO_F    = 8'h66;

  // All tokens caused by one character. Only the first token can carry
  // data; last_idx is the index of the final token.
  typedef struct packed {
    logic [1:0]                  last_idx;
    logic [7:0]                  data;
    tok_kind_e [MaxTokens-1:0]   kinds;
  } bundle_t;

endpackage

// File: sv/bat_front.sv
// Front end of the bus address tokenizer: takes one character a cycle while accept_i is high,
// tracks the open part and percent decoding, and builds a token bundle.
// Depends on bat_pkg.
module bat_front import bat_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] char_byte_i,
  input  logic       is_end_i,
  output logic       push_o,
  output bundle_t    bundle_o
);

  part_e      part_q, part_d;
  logic       addr_open_q, addr_open_d;
  logic       stopped_q, stopped_d;
  logic [1:0] hex_left_q, hex_left_d;
  logic [7:0] hex_acc_q, hex_acc_d;

  logic [2:0] n;
  logic       is_sep;
  logic       flush;
  logic [7:0] flush_byte;
  logic [7:0] acc_next;
  logic [3:0] hex_val;

  // Value of a hex digit; any other character counts as zero.
  always_comb begin
    if (char_byte_i >= CH_DIG_0 && char_byte_i <= CH_DIG_9) begin
      hex_val = 4'(char_byte_i - CH_DIG_0);
    end else if (char_byte_i >= CH_UP_A && char_byte_i <= CH_UP_F) begin
      hex_val = 4'(char_byte_i - CH_UP_A + 8'd10);
    end else if (char_byte_i >= CH_LO_A && char_byte_i <= CH_LO_F) begin
      hex_val = 4'(char_byte_i - CH_LO_A + 8'd10);
    end else begin
      hex_val = 4'd0;
    end
  end

  assign is_sep     = (char_byte_i == CH_SEMI) || (char_byte_i == CH_COMMA);
  assign flush      = (hex_left_q != 2'd0);
  // Missing digits of a cut-short sequence are taken as zero.
  assign flush_byte = (hex_left_q == 2'd1) ? {hex_acc_q[3:0], 4'd0} : 8'd0;
  assign acc_next   = {hex_acc_q[3:0], hex_val};

  // Parse decision and token bundle for the character on the input.
  always_comb begin
    part_d          = part_q;
    addr_open_d     = addr_open_q;
    stopped_d       = stopped_q;
    hex_left_d      = hex_left_q;
    hex_acc_d       = hex_acc_q;
    n               = 3'd0;
    bundle_o.data   = 8'd0;
    bundle_o.kinds  = '{default: TK_DONE};

    if (is_end_i) begin
      if (!stopped_q) begin
        if (part_q == PART_VALUE) begin
          if (flush) begin
            bundle_o.kinds[n[1:0]] = TK_VALUE_BYTE;
            bundle_o.data          = flush_byte;
            n                      = n + 3'd1;
          end
          bundle_o.kinds[n[1:0]] = TK_END_VALUE;
          n                      = n + 3'd1;
          bundle_o.kinds[n[1:0]] = TK_END_ADDRESS;
          n                      = n + 3'd1;
          bundle_o.kinds[n[1:0]] = TK_DONE;
          n                      = n + 3'd1;
        end else begin
          bundle_o.kinds[0] = addr_open_q ? TK_ERROR : TK_DONE;
          n                 = 3'd1;
        end
      end
      // The end marker always returns the parser to its reset state.
      part_d      = PART_TRANSPORT;
      addr_open_d = 1'b0;
      stopped_d   = 1'b0;
      hex_left_d  = 2'd0;
      hex_acc_d   = 8'd0;
    end else if (stopped_q) begin
      n = 3'd0;
    end else if (is_sep) begin
      if (part_q != PART_VALUE) begin
        bundle_o.kinds[0] = addr_open_q ? TK_ERROR : TK_DONE;
        n                 = 3'd1;
        stopped_d         = 1'b1;
        hex_left_d        = 2'd0;
        hex_acc_d         = 8'd0;
      end else begin
        if (flush) begin
          bundle_o.kinds[n[1:0]] = TK_VALUE_BYTE;
          bundle_o.data          = flush_byte;
          n                      = n + 3'd1;
        end
        hex_left_d             = 2'd0;
        hex_acc_d              = 8'd0;
        bundle_o.kinds[n[1:0]] = TK_END_VALUE;
        n                      = n + 3'd1;
        if (char_byte_i == CH_COMMA) begin
          part_d = PART_KEY;
        end else begin
          bundle_o.kinds[n[1:0]] = TK_END_ADDRESS;
          n                      = n + 3'd1;
          part_d                 = PART_TRANSPORT;
          addr_open_d            = 1'b0;
        end
      end
    end else begin
      addr_open_d = 1'b1;
      if (char_byte_i == CH_EQUALS) begin
        if (part_q != PART_KEY) begin
          bundle_o.kinds[0] = TK_ERROR;
          stopped_d         = 1'b1;
        end else begin
          bundle_o.kinds[0] = TK_END_KEY;
          part_d            = PART_VALUE;
        end
        n          = 3'd1;
        hex_left_d = 2'd0;
        hex_acc_d  = 8'd0;
      end else if (char_byte_i == CH_COLON) begin
        n = 3'd1;
        if (part_q == PART_KEY || part_q == PART_VALUE) begin
          bundle_o.kinds[0] = TK_ERROR;
          stopped_d         = 1'b1;
          hex_left_d        = 2'd0;
          hex_acc_d         = 8'd0;
        end else begin
          bundle_o.kinds[0] = TK_END_TRANSPORT;
          part_d            = PART_KEY;
        end
      end else if (part_q == PART_VALUE) begin
        if (flush) begin
          // Collect one more hex digit; the byte is out after the second.
          hex_left_d = hex_left_q - 2'd1;
          if (hex_left_q == 2'd1) begin
            bundle_o.kinds[0] = TK_VALUE_BYTE;
            bundle_o.data     = acc_next;
            n                 = 3'd1;
            hex_acc_d         = 8'd0;
          end else begin
            hex_acc_d = acc_next;
          end
        end else if (char_byte_i == CH_PERCENT) begin
          hex_left_d = 2'd2;
          hex_acc_d  = 8'd0;
        end else begin
          bundle_o.kinds[0] = TK_VALUE_BYTE;
          bundle_o.data     = char_byte_i;
          n                 = 3'd1;
        end
      end else if (part_q == PART_KEY) begin
        bundle_o.kinds[0] = TK_KEY_CHAR;
        bundle_o.data     = char_byte_i;
        n                 = 3'd1;
      end else begin
        bundle_o.kinds[0] = TK_TRANSPORT_CHAR;
        bundle_o.data     = char_byte_i;
        n                 = 3'd1;
      end
    end

    bundle_o.last_idx = 2'(n - 3'd1);
  end

  assign push_o = accept_i && (n != 3'd0);

  // Parser state advances on every accepted transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q      <= PART_TRANSPORT;
      addr_open_q <= 1'b0;
      stopped_q   <= 1'b0;
      hex_left_q  <= 2'd0;
      hex_acc_q   <= 8'd0;
    end else if (accept_i) begin
      part_q      <= part_d;
      addr_open_q <= addr_open_d;
      stopped_q   <= stopped_d;
      hex_left_q  <= hex_left_d;
      hex_acc_q   <= hex_acc_d;
    end
  end

endmodule

// File: sv/bat_queue.sv
// Short queue of token bundles between the front end and the back end.
// Depends on bat_pkg.
module bat_queue import bat_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t push_data_i,
  input  logic    pop_i,
  output bundle_t head_o,
  output logic    full_o,
  output logic    empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bundle_t             slots_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = slots_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Bundle storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: sv/bat_back.sv
// Back end of the bus address tokenizer: sends the head bundle's tokens one
// a cycle through an output register unless stalled. Depends on bat_pkg.
module bat_back import bat_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  bundle_t    head_i,
  input  logic       head_valid_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] token_kind_o,
  output logic [7:0] token_data_o,
  output logic       last_of_run_o
);

  logic [1:0] tok_idx_q, tok_idx_d;
  logic       valid_q, valid_d;
  logic [3:0] kind_q, kind_d;
  logic [7:0] data_q, data_d;
  logic       last_q, last_d;
  logic       load;
  logic       is_last;

  assign load    = head_valid_i && (!valid_q || out_ready_i);
  assign is_last = (tok_idx_q == head_i.last_idx);
  assign pop_o   = load && is_last;

  // Next token into the output register.
  always_comb begin
    tok_idx_d = tok_idx_q;
    kind_d    = kind_q;
    data_d    = data_q;
    last_d    = last_q;
    valid_d   = valid_q && !out_ready_i;
    if (load) begin
      valid_d   = 1'b1;
      kind_d    = head_i.kinds[tok_idx_q];
      data_d    = (tok_idx_q == 2'd0) ? head_i.data : 8'd0;
      last_d    = is_last;
      tok_idx_d = is_last ? 2'd0 : tok_idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_idx_q <= 2'd0;
      valid_q   <= 1'b0;
    end else begin
      tok_idx_q <= tok_idx_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    data_q <= data_d;
    last_q <= last_d;
  end

  assign out_valid_o   = valid_q;
  assign token_kind_o  = kind_q;
  assign token_data_o  = data_q;
  assign last_of_run_o = last_q;

endmodule

// File: sv/bus_address_tokenizer_top.sv
// Top level of the bus address tokenizer: front end, bundle queue and
// back end. Depends on bat_pkg, bat_front, bat_queue and bat_back.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_ready_o    char_byte_i, is_end_i
//   out      output     out_valid_o / out_ready_i  token_kind_o, token_data_o,
//                                                  last_of_run_o
//
// The front end takes one character every cycle while the queue has room.
// The back end sends one token a cycle while out_ready_i is high; a
// character that gives k tokens (k is at most four) holds the output
// until all are sent; the output register limits rate on multi-token runs.
// Reset clears parser state, queue pointers and the output valid flag.
// A stalled output fills the queue, after which in_ready_o falls.
module bus_address_tokenizer_top import bat_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_byte_i,
  input  logic       is_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] token_kind_o,
  output logic [7:0] token_data_o,
  output logic       last_of_run_o
);

  logic    accept;
  logic    push;
  logic    pop;
  logic    q_full;
  logic    q_empty;
  bundle_t push_bundle;
  bundle_t head_bundle;

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  // Character classification and parser state.
  bat_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_byte_i (char_byte_i),
    .is_end_i    (is_end_i),
    .push_o      (push),
    .bundle_o    (push_bundle)
  );

  // Decoupling queue.
  bat_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_bundle),
    .pop_i       (pop),
    .head_o      (head_bundle),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // Token serialiser and output register.
  bat_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_bundle),
    .head_valid_i  (!q_empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .token_kind_o  (token_kind_o),
    .token_data_o  (token_data_o),
    .last_of_run_o (last_of_run_o)
  );

`ifndef ASSERT_OFF
  // The front end never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_full)
    else $error("bundle pushed into a full queue");

  // Tokens without a character carry zero data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o != TK_TRANSPORT_CHAR && token_kind_o != TK_KEY_CHAR &&
    token_kind_o != TK_VALUE_BYTE |-> token_data_o == 8'd0)
    else $error("non-character token with data");

  // Done and error always close the run of a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o == TK_DONE || token_kind_o == TK_ERROR) |-> last_of_run_o)
    else $error("done or error not last of run");
`endif

endmodule
